// File: hdl/erm_pkg.sv
// Shared types and constants for the Euler angle to rotation matrix pipeline.
// No dependencies; every other file of the block but erm_checker imports this package.
package erm_pkg;

  // Field widths and fixed-point formats
  localparam int ANGLE_W    = 16;
  localparam int ELEM_W     = 16;
  localparam int ANGLE_FRAC = 6;
  localparam int ELEM_FRAC  = 14;
  localparam int CORDIC_N   = 16;
  localparam int WORK_W     = 34;
  localparam int PROD_W     = 2 * WORK_W;

  // Angle reduction constants (degrees with ANGLE_FRAC fraction bits)
  localparam int FULL_TURN = 360 << ANGLE_FRAC;
  localparam int QUARTER   = 90 << ANGLE_FRAC;
  localparam int RED_W     = $clog2(FULL_TURN);
  localparam int REM_W     = $clog2(QUARTER);
  localparam int SUM_W     = ANGLE_W + 2;

  // pi/180 in Q.40, and the shift that brings r*D to radians in Q.30
  localparam int       D_W         = 35;
  localparam logic [D_W-1:0] DEG2RAD_Q40 = 35'd19190098069;
  localparam int       RAD_W       = REM_W + D_W;
  localparam int       Z_SHIFT     = 10 + ANGLE_FRAC;

  // Pipeline depths outside the CORDIC
  localparam int PREP_LAT = 4;
  localparam int MAT_LAT  = 5;

  // Element finishing
  localparam int FIN_SHIFT = 60 - ELEM_FRAC;
  localparam int SAT       = 1 << ELEM_FRAC;

  typedef logic signed [WORK_W-1:0] work_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [1:0]               quad_t;
  typedef logic [ELEM_W-1:0]        elem_t;

  // Quadrant codes
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e_t;

  // CORDIC start value: 1/K for CORDIC_N stages, Q.30
  localparam work_t CORDIC_X0 = 34'sd652032874;

  // atan(2^-i) in Q.30, rounded
  function automatic work_t atan_q30(input int unsigned i);
    work_t v;
    case (i)
      0:       v = 34'sd843314857;
      1:       v = 34'sd497837829;
      2:       v = 34'sd263043837;
      3:       v = 34'sd133525159;
      4:       v = 34'sd67021687;
      5:       v = 34'sd33543516;
      6:       v = 34'sd16775851;
      7:       v = 34'sd8388437;
      8:       v = 34'sd4194283;
      9:       v = 34'sd2097149;
      default: v = (i < 31) ? (work_t'(1) <<< (30 - i)) : '0;
    endcase
    return v;
  endfunction

  // Round Q.60 half up to ELEM_FRAC bits and saturate to +-1.0
  function automatic elem_t finish(input prod_t v);
    prod_t t;
    t = (v + (prod_t'(1) <<< (FIN_SHIFT - 1))) >>> FIN_SHIFT;
    if (t > prod_t'(SAT)) t = prod_t'(SAT);
    if (t < -prod_t'(SAT)) t = -prod_t'(SAT);
    return t[ELEM_W-1:0];
  endfunction

endpackage

// File: hdl/erm_prep.sv
// Angle preparation: reduce modulo one turn, split quadrant, scale to radians.
// Depends on erm_pkg. Four register stages, all advanced by en.
module erm_prep (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [erm_pkg::ANGLE_W-1:0] angle_i,
  output erm_pkg::work_t                   z_o,
  output erm_pkg::quad_t                   q_o
);
  import erm_pkg::*;

  logic [RED_W-1:0] m_r, m_nxt;
  logic [REM_W-1:0] r_r, r_nxt;
  quad_t            q1_r, q1_nxt, q2_r, q3_r;
  logic [RAD_W-1:0] rad_r;
  work_t            z_r;

  // Reduce into [0, one turn)
  always_comb begin
    logic signed [SUM_W-1:0] s;
    logic [SUM_W-2:0]        u;
    s = SUM_W'(angle_i) + SUM_W'(2 * FULL_TURN);
    u = s[SUM_W-2:0];
    if (u >= (SUM_W-1)'(2 * FULL_TURN)) u = u - (SUM_W-1)'(2 * FULL_TURN);
    if (u >= (SUM_W-1)'(FULL_TURN)) u = u - (SUM_W-1)'(FULL_TURN);
    m_nxt = u[RED_W-1:0];
  end

  // Split quadrant and offset
  always_comb begin
    if (m_r >= RED_W'(3 * QUARTER)) begin
      q1_nxt = QUAD_3;
      r_nxt  = REM_W'(m_r - RED_W'(3 * QUARTER));
    end else if (m_r >= RED_W'(2 * QUARTER)) begin
      q1_nxt = QUAD_2;
      r_nxt  = REM_W'(m_r - RED_W'(2 * QUARTER));
    end else if (m_r >= RED_W'(QUARTER)) begin
      q1_nxt = QUAD_1;
      r_nxt  = REM_W'(m_r - RED_W'(QUARTER));
    end else begin
      q1_nxt = QUAD_0;
      r_nxt  = m_r[REM_W-1:0];
    end
  end

  // Advance the stages
  always_ff @(posedge clk) begin
    if (en) begin
      m_r   <= m_nxt;
      r_r   <= r_nxt;
      q1_r  <= q1_nxt;
      rad_r <= RAD_W'(r_r) * RAD_W'(DEG2RAD_Q40);
      q2_r  <= q1_r;
      z_r   <= work_t'((rad_r + RAD_W'(1 << (Z_SHIFT - 1))) >> Z_SHIFT);
      q3_r  <= q2_r;
    end
  end

  assign z_o = z_r;
  assign q_o = q3_r;

endmodule

// File: hdl/erm_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration, quadrant carried along.
// Depends on erm_pkg. Every stage advances with en.
module erm_cordic (
  input  logic           clk,
  input  logic           en,
  input  erm_pkg::work_t z_i,
  input  erm_pkg::quad_t q_i,
  output erm_pkg::work_t x_o,
  output erm_pkg::work_t y_o,
  output erm_pkg::quad_t q_o
);
  import erm_pkg::*;

  work_t x_r [CORDIC_N];
  work_t y_r [CORDIC_N];
  work_t z_r [CORDIC_N];
  quad_t q_r [CORDIC_N];

  for (genvar g = 0; g < CORDIC_N; g++) begin : g_stage
    work_t xp, yp, zp;
    quad_t qp;
    if (g == 0) begin : g_first
      assign xp = CORDIC_X0;
      assign yp = '0;
      assign zp = z_i;
      assign qp = q_i;
    end else begin : g_next
      assign xp = x_r[g-1];
      assign yp = y_r[g-1];
      assign zp = z_r[g-1];
      assign qp = q_r[g-1];
    end

    // Rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zp[WORK_W-1]) begin
          x_r[g] <= xp - (yp >>> g);
          y_r[g] <= yp + (xp >>> g);
          z_r[g] <= zp - atan_q30(g);
        end else begin
          x_r[g] <= xp + (yp >>> g);
          y_r[g] <= yp - (xp >>> g);
          z_r[g] <= zp + atan_q30(g);
        end
        q_r[g] <= qp;
      end
    end
  end

  assign x_o = x_r[CORDIC_N-1];
  assign y_o = y_r[CORDIC_N-1];
  assign q_o = q_r[CORDIC_N-1];

endmodule

// File: hdl/erm_matrix.sv
// Matrix element pipeline: quadrant fix, products, sums, rounding and transpose.
// Depends on erm_pkg. Five register stages; the last is the output word register.
module erm_matrix (
  input  logic           clk,
  input  logic           en,
  input  erm_pkg::work_t xp_i, yp_i, xw_i, yw_i, xl_i, yl_i,
  input  erm_pkg::quad_t qp_i, qw_i, ql_i,
  input  logic           tr_i,
  output erm_pkg::elem_t m_o [9]
);
  import erm_pkg::*;

  // Stage 1: sine and cosine after quadrant rotation
  work_t sr_r, cr_r, sp_r, cp_r, sy_r, cy_r;
  logic  tr1_r, tr2_r, tr3_r, tr4_r;

  function automatic work_t rot_c(input quad_t q, input work_t x, input work_t y);
    work_t v;
    case (q)
      QUAD_0:  v = x;
      QUAD_1:  v = -y;
      QUAD_2:  v = -x;
      default: v = y;
    endcase
    return v;
  endfunction

  function automatic work_t rot_s(input quad_t q, input work_t x, input work_t y);
    work_t v;
    case (q)
      QUAD_0:  v = y;
      QUAD_1:  v = x;
      QUAD_2:  v = -y;
      default: v = -x;
    endcase
    return v;
  endfunction

  // Stage 2: pair products
  prod_t spcy_r, spsy_r, cpcy_r, cpsy_r, srcp_r, crcp_r, srsy_r, srcy_r, crsy_r, crcy_r;
  work_t sr2_r, cr2_r, sp2_r, sp3_r;

  // Stage 3: triple products, pairs carried
  prod_t srspcy_r, crspcy_r, srspsy_r, crspsy_r;
  prod_t cpcy3_r, cpsy3_r, srcp3_r, crcp3_r, srsy3_r, srcy3_r, crsy3_r, crcy3_r;

  // Stage 4: elements at Q.60, row-major
  prod_t e_r [9];

  // Stage 5: output words
  elem_t m_r [9];

  work_t spcy_rd, spsy_rd;
  assign spcy_rd = work_t'((spcy_r + (prod_t'(1) <<< 29)) >>> 30);
  assign spsy_rd = work_t'((spsy_r + (prod_t'(1) <<< 29)) >>> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      // rotate by quadrant
      sr_r  <= rot_s(qp_i, xp_i, yp_i);
      cr_r  <= rot_c(qp_i, xp_i, yp_i);
      sp_r  <= rot_s(qw_i, xw_i, yw_i);
      cp_r  <= rot_c(qw_i, xw_i, yw_i);
      sy_r  <= rot_s(ql_i, xl_i, yl_i);
      cy_r  <= rot_c(ql_i, xl_i, yl_i);
      tr1_r <= tr_i;
      // pair products
      spcy_r <= prod_t'(sp_r) * prod_t'(cy_r);
      spsy_r <= prod_t'(sp_r) * prod_t'(sy_r);
      cpcy_r <= prod_t'(cp_r) * prod_t'(cy_r);
      cpsy_r <= prod_t'(cp_r) * prod_t'(sy_r);
      srcp_r <= prod_t'(sr_r) * prod_t'(cp_r);
      crcp_r <= prod_t'(cr_r) * prod_t'(cp_r);
      srsy_r <= prod_t'(sr_r) * prod_t'(sy_r);
      srcy_r <= prod_t'(sr_r) * prod_t'(cy_r);
      crsy_r <= prod_t'(cr_r) * prod_t'(sy_r);
      crcy_r <= prod_t'(cr_r) * prod_t'(cy_r);
      sr2_r  <= sr_r;
      cr2_r  <= cr_r;
      sp2_r  <= sp_r;
      tr2_r  <= tr1_r;
      // triple products from the rounded yaw-roll pairs
      srspcy_r <= prod_t'(sr2_r) * prod_t'(spcy_rd);
      crspcy_r <= prod_t'(cr2_r) * prod_t'(spcy_rd);
      srspsy_r <= prod_t'(sr2_r) * prod_t'(spsy_rd);
      crspsy_r <= prod_t'(cr2_r) * prod_t'(spsy_rd);
      cpcy3_r  <= cpcy_r;
      cpsy3_r  <= cpsy_r;
      srcp3_r  <= srcp_r;
      crcp3_r  <= crcp_r;
      srsy3_r  <= srsy_r;
      srcy3_r  <= srcy_r;
      crsy3_r  <= crsy_r;
      crcy3_r  <= crcy_r;
      sp3_r    <= sp2_r;
      tr3_r    <= tr2_r;
      // form elements
      e_r[0] <= cpcy3_r;
      e_r[1] <= srspcy_r - crsy3_r;
      e_r[2] <= crspcy_r + srsy3_r;
      e_r[3] <= cpsy3_r;
      e_r[4] <= srspsy_r + crcy3_r;
      e_r[5] <= crspsy_r - srcy3_r;
      e_r[6] <= -(prod_t'(sp3_r) <<< 30);
      e_r[7] <= srcp3_r;
      e_r[8] <= crcp3_r;
      tr4_r  <= tr3_r;
    end
  end

  // Round, saturate and optionally transpose into the output word
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          m_r[r*3+c] <= finish(tr4_r ? e_r[c*3+r] : e_r[r*3+c]);
        end
      end
      assign m_o[r*3+c] = m_r[r*3+c];
    end
  end

endmodule

// File: hdl/euler_to_rotation_matrix.sv
// Top level of the Euler angle to rotation matrix pipeline.
// Depends on erm_pkg, erm_prep, erm_cordic and erm_matrix.
//
// Usage:
//   Input channel in_*: one word per angle triple. in_tdata carries pitch,
//   yaw and roll in degrees (signed Q10.6); in_tuser is the transpose flag.
//   Output channel out_*: one word per input word, the nine elements of the
//   3x3 matrix in signed Q1.14, saturated to +-1.0, rows then columns.
//   Path from acceptance to out_tvalid: angle reduction and radian scaling,
//   the CORDIC iterations, then products, sums and rounding. Throughput:
//   one word per cycle while the output is not stalled; each CORDIC iteration
//   and each multiplier has its own register stage.
//   Reset (rst_n low, synchronous) empties the pipeline: out_tvalid drops.
//   Stall: when out_tvalid is high and out_tready low the whole pipeline
//   holds, in_tready drops and the output word stays as it is; nothing is
//   lost or repeated. in_tready is high whenever the output register is empty
//   or being taken.
module euler_to_rotation_matrix (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // pitch_deg[15:0], yaw_deg[31:16], roll_deg[47:32]
  input  logic         in_tuser,   // transpose[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each
);
  import erm_pkg::*;

  localparam int TR_LAT   = PREP_LAT + CORDIC_N;
  localparam int PIPE_LAT = TR_LAT + MAT_LAT;

  logic                en;
  logic [PIPE_LAT-1:0] vld_r, vld_nxt;
  logic [TR_LAT-1:0]   tr_r;

  work_t zp, zw, zl, xp, yp, xw, yw, xl, yl;
  quad_t qp0, qw0, ql0, qp, qw, ql;
  elem_t m [9];

  // Advance everything when the output word is empty or taken
  assign en        = !vld_r[PIPE_LAT-1] || out_tready;
  assign in_tready = en;
  assign vld_nxt   = {vld_r[PIPE_LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Carry the transpose flag alongside the angle lanes
  always_ff @(posedge clk) begin
    if (en) begin
      tr_r <= {tr_r[TR_LAT-2:0], in_tuser};
    end
  end

  erm_prep u_prep_p (.clk, .en, .angle_i(in_tdata[15:0]),  .z_o(zp), .q_o(qp0));
  erm_prep u_prep_w (.clk, .en, .angle_i(in_tdata[31:16]), .z_o(zw), .q_o(qw0));
  erm_prep u_prep_l (.clk, .en, .angle_i(in_tdata[47:32]), .z_o(zl), .q_o(ql0));

  erm_cordic u_cordic_p (.clk, .en, .z_i(zp), .q_i(qp0), .x_o(xp), .y_o(yp), .q_o(qp));
  erm_cordic u_cordic_w (.clk, .en, .z_i(zw), .q_i(qw0), .x_o(xw), .y_o(yw), .q_o(qw));
  erm_cordic u_cordic_l (.clk, .en, .z_i(zl), .q_i(ql0), .x_o(xl), .y_o(yl), .q_o(ql));

  erm_matrix u_matrix (
    .clk, .en,
    .xp_i(xp), .yp_i(yp), .xw_i(xw), .yw_i(yw), .xl_i(xl), .yl_i(yl),
    .qp_i(qp), .qw_i(qw), .ql_i(ql),
    .tr_i(tr_r[TR_LAT-1]),
    .m_o(m)
  );

  assign out_tvalid = vld_r[PIPE_LAT-1];
  assign out_tdata  = {m[8], m[7], m[6], m[5], m[4], m[3], m[2], m[1], m[0]};

endmodule

// File: hdl/erm_checker.sv
// Port-level checks for euler_to_rotation_matrix, attached by bind.
// Depends only on the top level's ports.
module erm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata
);

  // Hold a stalled output word
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // Accept input exactly when the output side can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output backpressure");

  // Keep the first and last diagonal elements (m00, m22) within +-1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd16384) &&
                   ($signed(out_tdata[15:0]) >= -16'sd16384) &&
                   ($signed(out_tdata[143:128]) <= 16'sd16384) &&
                   ($signed(out_tdata[143:128]) >= -16'sd16384))
    else $error("element beyond unit range");

endmodule

bind euler_to_rotation_matrix erm_checker u_erm_checker (.*);

// File: tb/tb_euler_to_rotation_matrix.sv
// Self-checking testbench for euler_to_rotation_matrix: angle triples in, matrices out.
// Uses its own fixed-point CORDIC predictor; depends on erm_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_euler_to_rotation_matrix;
  import erm_pkg::*;

  typedef struct {
    logic [15:0] elem [9];
  } matrix_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  in_tdata;    // pitch_deg[15:0], yaw_deg[31:16], roll_deg[47:32]
  logic         in_tuser;    // transpose[0]
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;   // m00, m01, m02, m10, m11, m12, m20, m21, m22

  matrix_t matrix_queue[$];
  int      errors;
  int      results_seen;
  bit      idling_on;

  // Predictor constants, derived at start-up
  longint  atan_tab [32];
  longint  pi_per_deg_q40;
  longint  gain_inv_q30;

  euler_to_rotation_matrix u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round half up then shift right arithmetically
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // atan(1/n) in Q.60 by the alternating series
  function automatic longint atan_recip(longint unsigned n);
    longint unsigned x;
    longint unsigned nn;
    longint          sum;
    longint unsigned k;
    x = (64'd1 << 60) / n;
    nn = n * n;
    sum = 0;
    k = 0;
    while (x != 0) begin
      if (k[0]) sum = sum - longint'(x / (2 * k + 1));
      else sum = sum + longint'(x / (2 * k + 1));
      x = x / nn;
      k++;
    end
    return sum;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic derive_constants();
    longint          quarter_pi;
    longint unsigned pi60;
    longint unsigned p;
    longint unsigned ksq;
    quarter_pi = 4 * atan_recip(5) - atan_recip(239);
    pi60 = longint'(quarter_pi) * 4;
    pi_per_deg_q40 = longint'((pi60 / 180 + (64'd1 << 19)) >> 20);
    atan_tab[0] = round_shift(quarter_pi, 30);
    for (int i = 1; i < 32; i++) atan_tab[i] = round_shift(atan_recip(64'd1 << i), 30);
    p = 64'd1 << 60;
    for (int i = 0; i < CORDIC_N; i++) p = p + (p >> (2 * i));
    ksq = (64'd1 << 60) / (p >> 30);
    gain_inv_q30 = longint'(int_sqrt(ksq << 30));
  endtask

  // Sine and cosine in Q.30 of a Q10.6 degree angle
  task automatic angle_sincos(input logic signed [15:0] a, output longint sn,
                              output longint cs);
    int        full_turn;
    int        quarter_turn;
    int        m;
    int        q;
    int        r;
    longint    x;
    longint    y;
    longint    z;
    longint    dx;
    longint    dy;
    quad_e_t   quad;
    full_turn = 360 << ANGLE_FRAC;
    quarter_turn = 90 << ANGLE_FRAC;
    m = int'(a) % full_turn;
    if (m < 0) m += full_turn;
    q = m / quarter_turn;
    r = m - q * quarter_turn;
    z = round_shift(longint'(r) * pi_per_deg_q40, 10 + ANGLE_FRAC);
    x = gain_inv_q30;
    y = 0;
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    quad = quad_e_t'(q[1:0]);
    case (quad)
      QUAD_0: begin cs = x;  sn = y;  end
      QUAD_1: begin cs = -y; sn = x;  end
      QUAD_2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endtask

  function automatic logic [15:0] round_saturate(longint v60);
    longint v;
    v = round_shift(v60, 60 - ELEM_FRAC);
    if (v > SAT) v = SAT;
    if (v < -SAT) v = -SAT;
    return v[15:0];
  endfunction

  task automatic predict_matrix(input logic [47:0] angles, input logic tr,
                                output matrix_t mx);
    longint sr, cr, sp, cp, sy, cy, spcy, spsy;
    longint e [3][3];
    angle_sincos(angles[15:0], sr, cr);
    angle_sincos(angles[31:16], sp, cp);
    angle_sincos(angles[47:32], sy, cy);
    spcy = round_shift(sp * cy, 30);
    spsy = round_shift(sp * sy, 30);
    e[0][0] = cp * cy;
    e[1][0] = cp * sy;
    e[2][0] = -sp * (longint'(1) << 30);
    e[0][1] = sr * spcy - cr * sy;
    e[1][1] = sr * spsy + cr * cy;
    e[2][1] = sr * cp;
    e[0][2] = cr * spcy + sr * sy;
    e[1][2] = cr * spsy - sr * cy;
    e[2][2] = cr * cp;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        mx.elem[r * 3 + c] = round_saturate(tr ? e[c][r] : e[r][c]);
  endtask

  task automatic report_mismatch(string what, int idx, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("mismatch %s result %0d elem %0d: got %h want %h", what, results_seen, idx,
             got, want);
  endtask

  // Send one word, then sometimes hold off for a random burst when idling is on
  task automatic send_angles(input logic [15:0] pitch, input logic [15:0] yaw,
                             input logic [15:0] roll, input logic tr);
    matrix_t mx;
    in_tvalid <= 1'b1;
    in_tdata  <= {roll, yaw, pitch};
    in_tuser  <= tr;
    predict_matrix({roll, yaw, pitch}, tr, mx);
    do @(posedge clk); while (!in_tready);
    matrix_queue.push_back(mx);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Sink stalls in random bursts
  initial begin
    int hold;
    out_tready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        hold = $urandom_range(0, 12);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Check each accepted matrix against the oldest prediction
  always @(posedge clk) begin
    matrix_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (matrix_queue.size() == 0) begin
        report_mismatch("unexpected", 0, out_tdata[15:0], 'x);
      end else begin
        want = matrix_queue.pop_front();
        for (int i = 0; i < 9; i++)
          if (out_tdata[i*16 +: 16] !== want.elem[i])
            report_mismatch("matrix", i, out_tdata[i*16 +: 16], want.elem[i]);
      end
      results_seen++;
    end
  end

  localparam logic [15:0] DEG = 16'd64;

  // Quarter turns, extremes, wrap beyond one turn and both matrix forms
  task automatic test_directed();
    logic [15:0] pts [12];
    pts = '{16'd0, 90 * DEG, 180 * DEG, 270 * DEG, -(90 * DEG), 16'h7fff, 16'h8000,
            45 * DEG, 400 * DEG, -(400 * DEG), 16'hffff, 16'd1};
    for (int i = 0; i < 12; i++)
      send_angles(pts[i], pts[(i + 3) % 12], pts[(i + 7) % 12], i[0]);
    send_angles(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_angles(16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_angles(30 * DEG, 60 * DEG, 10 * DEG, 1'b0);
    send_angles(30 * DEG, 60 * DEG, 10 * DEG, 1'b1);
    // near-unit elements that may round past one
    send_angles(16'd0, 16'd1, 360 * DEG - 1, 1'b0);
    send_angles(90 * DEG, 16'd0, 90 * DEG, 1'b1);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 7) * 45 * 64 - 180 * 64);
      2: return 16'($urandom_range(0, 720 * 64) - 360 * 64);
      default: return 16'($urandom_range(0, 15) * 90 * 64 + $urandom_range(0, 3) - 1);
    endcase
  endfunction

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_angles(pick_angle(), pick_angle(), pick_angle(), 1'($urandom_range(0, 1)));
  endtask

  // Back-to-back words with the sink always ready
  task automatic test_full_rate(int count);
    idling_on = 1'b0;
    test_random(count);
    in_tvalid <= 1'b0;
  endtask

  initial begin
    int waited;
    errors = 0;
    results_seen = 0;
    idling_on = 1'b1;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    rst_n = 1'b0;
    derive_constants();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(450);
    test_full_rate(100);
    waited = 0;
    while (matrix_queue.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && matrix_queue.size() == 0) begin
      $display("euler_to_rotation_matrix verification clean");
    end else begin
      $display("euler_to_rotation_matrix verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("euler_to_rotation_matrix verification failed");
    $finish;
  end

endmodule
